// ----- hdl/rfce_pkg.sv -----
package rfce_pkg;

   localparam int PIXELS_DEF = 64;
   localparam int COLORS     = 3;
   localparam int VAL_W      = 8;
   localparam int ACT_W      = 3;
   localparam int DIV_STEPS  = VAL_W;

   localparam logic [ACT_W-1:0] ACT_WR_CANVAS = 3'd0;
   localparam logic [ACT_W-1:0] ACT_WR_TARGET = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WR_MASK   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_START     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_TICK      = 3'd4;
   localparam logic [ACT_W-1:0] ACT_RD_CANVAS = 3'd5;

   localparam logic CSR_TOTAL_STEPS = 1'b0;
   localparam logic CSR_MASK_ENABLE = 1'b1;

   typedef struct packed {
      logic capture;
      logic clear_wr;
      logic exec;
      logic rd_issue;
      logic sweep_rst;
      logic sweep_adv;
      logic sweep_rd;
      logic div_load;
      logic div_step;
      logic sweep_wr;
      logic step_inc;
      logic rsp_load;
   } rfce_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             tick_live;
      logic             skip;
      logic             sweep_last;
      logic             rsp_busy;
   } rfce_sts_type;

endpackage

// ----- hdl/rfce_ctrl.sv -----
module rfce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rfce_pkg::rfce_sts_type sts,
   output rfce_pkg::rfce_cmd_type cmd
);
   import rfce_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_RDWAIT = 4'd3;
   localparam logic [3:0] S_TREAD  = 4'd4;
   localparam logic [3:0] S_TLOAD  = 4'd5;
   localparam logic [3:0] S_TDIV   = 4'd6;
   localparam logic [3:0] S_TWRITE = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam int DCNT_W = $clog2(DIV_STEPS);

   logic [3:0]        state_ff, state_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   always_comb begin
      state_in  = state_ff;
      dcnt_in   = dcnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zeroes the canvas and the mask, one channel per cycle.
            cmd.clear_wr = 1'b1;
            if (sts.sweep_last) begin
               cmd.sweep_rst = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.sweep_adv = 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.action)
               ACT_TICK: begin
                  if (sts.tick_live) begin
                     cmd.sweep_rst = 1'b1;
                     state_in      = S_TREAD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               ACT_RD_CANVAS: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_RDWAIT;
               end
               default: begin
                  cmd.exec = 1'b1;
                  state_in = S_DONE;
               end
            endcase
         end
         S_RDWAIT: begin
            state_in = S_DONE;
         end
         S_TREAD: begin
            cmd.sweep_rd = 1'b1;
            state_in     = S_TLOAD;
         end
         S_TLOAD: begin
            if (sts.skip) begin
               if (sts.sweep_last) begin
                  cmd.step_inc = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.sweep_adv = 1'b1;
                  state_in      = S_TREAD;
               end
            end else begin
               cmd.div_load = 1'b1;
               dcnt_in      = '0;
               state_in     = S_TDIV;
            end
         end
         S_TDIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_TWRITE;
            end
         end
         S_TWRITE: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               cmd.step_inc = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.sweep_adv = 1'b1;
               state_in      = S_TREAD;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule

// ----- hdl/rfce_dpath.sv -----
module rfce_dpath #(
   parameter int PIXELS = rfce_pkg::PIXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rfce_pkg::ACT_W-1:0]    req_action,
   input  logic [7:0]                    req_index,
   input  logic [rfce_pkg::VAL_W-1:0]    req_value,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [7:0]                    csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfce_pkg::VAL_W-1:0]    rsp_read_data,
   output logic [7:0]                    rsp_step_count,
   output logic                          rsp_done_res,
   input  rfce_pkg::rfce_cmd_type        cmd,
   output rfce_pkg::rfce_sts_type        sts
);
   import rfce_pkg::*;

   localparam int CHANNELS = PIXELS * COLORS;
   localparam int CH_W     = $clog2(CHANNELS);
   localparam int PIX_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int IDX_AW   = ((CH_W > 8) ? CH_W : 8) + 1;
   localparam int PIX_AW   = ((PIX_W > 8) ? PIX_W : 8) + 1;

   // Stores
   logic [VAL_W-1:0] canvas_mem [CHANNELS];
   logic [VAL_W-1:0] target_mem [CHANNELS];
   logic             mask_mem   [PIXELS];
   logic [VAL_W-1:0] canvas_q_ff;
   logic [VAL_W-1:0] target_q_ff;
   logic             mask_q_ff;

   // Captured request
   logic [ACT_W-1:0] act_ff;
   logic [7:0]       idx_ff;
   logic [VAL_W-1:0] val_ff;

   // Configuration and step count
   logic [7:0] total_ff;
   logic       mask_en_ff;
   logic [7:0] step_ff, step_in;

   // Sweep position
   logic [CH_W-1:0]  k_ff;
   logic [1:0]       col_ff;
   logic [PIX_W-1:0] pix_ff;

   // Serial divider
   logic [VAL_W-1:0] quo_ff, rem_ff, den_ff, d_ff;
   logic             neg_ff;
   logic [VAL_W:0]   shifted;
   logic [VAL_W:0]   diff;
   logic             ge;
   logic [VAL_W-1:0] new_val;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_read_data_ff;
   logic [7:0]       rsp_step_count_ff;
   logic             rsp_done_res_ff;

   logic [IDX_AW-1:0] idx_ext;
   logic [PIX_AW-1:0] pidx_ext;
   logic              idx_ok, pix_ok;
   logic [CH_W-1:0]   idx_addr;
   logic [PIX_W-1:0]  pidx_addr;

   logic             cv_we, cv_re, tg_we, mk_we;
   logic [CH_W-1:0]  cv_waddr, cv_raddr;
   logic [VAL_W-1:0] cv_wdata;
   logic [PIX_W-1:0] mk_addr;
   logic             mk_wdata;

   assign idx_ext   = IDX_AW'(idx_ff);
   assign pidx_ext  = PIX_AW'(idx_ff);
   assign idx_ok    = idx_ext < IDX_AW'(CHANNELS);
   assign pix_ok    = pidx_ext < PIX_AW'(PIXELS);
   assign idx_addr  = idx_ext[CH_W-1:0];
   assign pidx_addr = pidx_ext[PIX_W-1:0];

   assign cv_we    = cmd.clear_wr | cmd.sweep_wr
                   | (cmd.exec & (act_ff == ACT_WR_CANVAS) & idx_ok);
   assign cv_waddr = (cmd.clear_wr | cmd.sweep_wr) ? k_ff : idx_addr;
   assign cv_wdata = cmd.clear_wr ? '0 : (cmd.sweep_wr ? new_val : val_ff);
   assign cv_re    = cmd.rd_issue | cmd.sweep_rd;
   assign cv_raddr = cmd.sweep_rd ? k_ff : idx_addr;

   assign tg_we = cmd.exec & (act_ff == ACT_WR_TARGET) & idx_ok;

   // The mask entry of a pixel is cleared once, on its first color.
   assign mk_we    = (cmd.clear_wr & (col_ff == 2'd0))
                   | (cmd.exec & (act_ff == ACT_WR_MASK) & pix_ok);
   assign mk_addr  = (cmd.clear_wr | cmd.sweep_rd) ? pix_ff : pidx_addr;
   assign mk_wdata = cmd.clear_wr ? 1'b0 : val_ff[0];

   always_ff @(posedge clock) begin
      if (cv_we) begin
         canvas_mem[cv_waddr] <= cv_wdata;
      end
      if (cv_re) begin
         canvas_q_ff <= canvas_mem[cv_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tg_we) begin
         target_mem[idx_addr] <= val_ff;
      end
      if (cmd.sweep_rd) begin
         target_q_ff <= target_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mk_we) begin
         mask_mem[mk_addr] <= mk_wdata;
      end
      if (cmd.sweep_rd) begin
         mask_q_ff <= mask_mem[mk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         mask_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TOTAL_STEPS) begin
            total_ff <= csr_wdata;
         end else begin
            mask_en_ff <= csr_wdata[0];
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.exec && (act_ff == ACT_START)) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_rst) begin
         k_ff   <= '0;
         col_ff <= '0;
         pix_ff <= '0;
      end else if (cmd.sweep_adv) begin
         k_ff <= k_ff + 1'b1;
         if (col_ff == 2'(COLORS - 1)) begin
            col_ff <= '0;
            pix_ff <= pix_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 2'd1;
         end
      end
   end

   // Restoring divide of |target - canvas| by the remaining step count.
   assign shifted = {rem_ff, quo_ff[VAL_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};
   assign new_val = neg_ff ? (d_ff - quo_ff) : (d_ff + quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         d_ff   <= canvas_q_ff;
         neg_ff <= target_q_ff < canvas_q_ff;
         quo_ff <= (target_q_ff < canvas_q_ff) ? (canvas_q_ff - target_q_ff)
                                              : (target_q_ff - canvas_q_ff);
         rem_ff <= '0;
         den_ff <= total_ff - step_ff;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
         quo_ff <= {quo_ff[VAL_W-2:0], ge};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_data_ff  <= ((act_ff == ACT_RD_CANVAS) && idx_ok) ? canvas_q_ff : '0;
         rsp_step_count_ff <= step_ff;
         rsp_done_res_ff   <= step_ff >= total_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_step_count = rsp_step_count_ff;
   assign rsp_done_res   = rsp_done_res_ff;

   assign sts.action     = act_ff;
   assign sts.tick_live  = step_ff < total_ff;
   assign sts.skip       = mask_en_ff & ~mask_q_ff;
   assign sts.sweep_last = k_ff == CH_W'(CHANNELS - 1);
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_ready;

endmodule

// ----- hdl/rgb_frame_crossfade_engine_core.sv -----
// A write, start or idle tick passes S_EXEC and S_DONE before rsp_valid; a read also
// passes S_RDWAIT. A fading tick walks every channel: read, load, serial divide and
// write-back per faded channel, only read and load per masked-off channel.
// One word is in flight at a time; the next is taken while the previous response waits.
// Reset (synchronous, active high) starts a pass over all PIXELS*3 channels that zeroes
// canvas and mask; req_ready stays low until it ends. Config writes are taken at any time.
module rgb_frame_crossfade_engine_core #(
   parameter int PIXELS = rfce_pkg::PIXELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rfce_pkg::ACT_W-1:0] req_action,
   input  logic [7:0]                 req_index,
   input  logic [rfce_pkg::VAL_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rfce_pkg::VAL_W-1:0] rsp_read_data,
   output logic [7:0]                 rsp_step_count,
   output logic                       rsp_done_res,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [7:0]                 csr_wdata
);
   import rfce_pkg::*;

   rfce_cmd_type cmd;
   rfce_sts_type sts;

   assign csr_ready = 1'b1;

   rfce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfce_dpath #(
      .PIXELS (PIXELS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_value      (req_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_step_count (rsp_step_count),
      .rsp_done_res   (rsp_done_res),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

// ----- hdl/rfce_checker.sv -----
module rfce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic [7:0] rsp_step_count,
   input logic       rsp_done_res
);

   // The clearing pass holds off requests right after reset.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // One word at a time: ready drops after an accept.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_read_data) && $stable(rsp_step_count) && $stable(rsp_done_res)))
      else $error("response payload changed while stalled");

endmodule

bind rgb_frame_crossfade_engine_core rfce_checker u_rfce_checker (.*);

// ----- bench/tb_top.sv -----
module tb_top;
   import rfce_pkg::*;

   localparam int CHANNELS = PIXELS_DEF * COLORS;
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
   localparam int HANG_LIMIT = 20000;
   localparam int STALL_CYCLES = 400;
   localparam int IDLE_PCT = 17;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] step_count;
      logic       done_res;
   } crossfade_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [ACT_W-1:0] req_action = '0;
   logic [7:0]       req_index = '0;
   logic [VAL_W-1:0] req_value = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VAL_W-1:0] rsp_read_data;
   logic [7:0]       rsp_step_count;
   logic             rsp_done_res;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = 1'b0;
   logic [7:0]       csr_wdata = '0;

   // Shadow copy of the engine state, advanced as each word is accepted.
   logic [7:0]           canvas_mem [CHANNELS];
   logic [7:0]           target_mem [CHANNELS];
   logic                 mask_mem [PIXELS_DEF];
   logic [7:0]           step_now = '0;
   logic [7:0]           steps_cfg = '0;
   logic                 mask_on = 1'b0;
   crossfade_result_type pending_results[$];

   int fault_count = 0;
   int quiet_cycles = 0;
   int stall_orders = 0;
   int stall_served = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   rgb_frame_crossfade_engine_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_step_count (rsp_step_count),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic crossfade_result_type apply_word(input logic [ACT_W-1:0] act,
                                                       input logic [7:0] idx,
                                                       input logic [7:0] val);
      crossfade_result_type res;
      int den;
      int diff;
      res.read_data = '0;
      case (act)
         ACT_WR_CANVAS: if (idx < CHANNELS) canvas_mem[idx] = val;
         ACT_WR_TARGET: if (idx < CHANNELS) target_mem[idx] = val;
         ACT_WR_MASK:   if (idx < PIXELS_DEF) mask_mem[idx] = val[0];
         ACT_START:     step_now = '0;
         ACT_TICK: begin
            if (step_now < steps_cfg) begin
               den = int'(steps_cfg) - int'(step_now);
               for (int k = 0; k < CHANNELS; k++) begin
                  if (!mask_on || mask_mem[k / COLORS]) begin
                     // Integer division truncates toward zero, as the fade requires.
                     diff = int'(target_mem[k]) - int'(canvas_mem[k]);
                     canvas_mem[k] = 8'(int'(canvas_mem[k]) + diff / den);
                  end
               end
               step_now = step_now + 8'd1;
            end
         end
         ACT_RD_CANVAS: if (idx < CHANNELS) res.read_data = canvas_mem[idx];
         default: ;
      endcase
      res.step_count = step_now;
      res.done_res = (step_now >= steps_cfg);
      return res;
   endfunction

   task automatic send_word(input logic [ACT_W-1:0] act, input logic [7:0] idx,
                            input logic [7:0] val);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_word(act, idx, val));
   endtask

   task automatic send_random_word();
      int roll;
      logic [ACT_W-1:0] act;
      logic [7:0] idx;
      roll = $urandom_range(99);
      if (roll < 20) begin
         act = ACT_WR_CANVAS;
      end else if (roll < 33) begin
         act = ACT_WR_TARGET;
      end else if (roll < 43) begin
         act = ACT_WR_MASK;
      end else if (roll < 47) begin
         act = ACT_START;
      end else if (roll < 62) begin
         act = ACT_TICK;
      end else if (roll < 96) begin
         act = ACT_RD_CANVAS;
      end else begin
         act = ($urandom_range(1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
      end
      if (act == ACT_WR_MASK) begin
         idx = ($urandom_range(99) < 8) ? 8'($urandom_range(255, PIXELS_DEF))
                                        : 8'($urandom_range(PIXELS_DEF - 1));
      end else begin
         idx = ($urandom_range(99) < 8) ? 8'($urandom_range(255, CHANNELS))
                                        : 8'($urandom_range(CHANNELS - 1));
      end
      send_word(act, idx, 8'($urandom));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Both registers are written back to back while nothing is in flight.
   task automatic write_regs(input logic [7:0] steps, input logic men);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_TOTAL_STEPS;
      csr_wdata <= steps;
      do @(posedge clock); while (!csr_ready);
      steps_cfg = steps;
      csr_index <= CSR_MASK_ENABLE;
      csr_wdata <= {7'($urandom), men};
      do @(posedge clock); while (!csr_ready);
      mask_on = men;
      csr_valid <= 1'b0;
   endtask

   task automatic test_store_access();
      send_word(ACT_WR_CANVAS, 8'd0, 8'hFF);
      send_word(ACT_WR_CANVAS, 8'd191, 8'h80);
      send_word(ACT_WR_CANVAS, 8'd192, 8'hAA);
      send_word(ACT_WR_CANVAS, 8'd255, 8'h55);
      send_word(ACT_RD_CANVAS, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd191, 8'hFF);
      send_word(ACT_RD_CANVAS, 8'd100, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd192, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd255, 8'h00);
      send_word(ACT_WR_MASK, 8'd0, 8'h01);
      send_word(ACT_WR_MASK, 8'd63, 8'hFE);
      send_word(ACT_WR_MASK, 8'd64, 8'h01);
      send_word(ACT_WR_MASK, 8'd255, 8'hFF);
      send_word(ACT_WR_TARGET, 8'd192, 8'h12);
      send_word(ACT_WR_TARGET, 8'd255, 8'h34);
      send_word(ACT_SPARE_6, 8'd7, 8'hFF);
      send_word(ACT_SPARE_7, 8'd0, 8'h00);
      // Total steps is still zero, so the tick only reports done.
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_START, 8'd0, 8'h00);
   endtask

   // Every target byte is written before any fade can read it.
   task automatic test_load_targets();
      logic [7:0] val;
      for (int k = 0; k < CHANNELS; k++) begin
         val = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
         send_word(ACT_WR_TARGET, 8'(k), val);
      end
   endtask

   task automatic test_fade_extremes();
      write_regs(8'd1, 1'b0);
      send_word(ACT_START, 8'd0, 8'h00);
      // A single-step fade lands every channel on its target.
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd191, 8'h00);
      send_word(ACT_TICK, 8'd0, 8'h00);
      for (int k = 0; k < 6; k++) send_word(ACT_WR_CANVAS, 8'(k), 8'($urandom));
      send_word(ACT_WR_CANVAS, 8'd189, 8'h00);
      write_regs(8'd255, 1'b1);
      send_word(ACT_START, 8'd0, 8'h00);
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd3, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd189, 8'h00);
      // Lowering the total below the step count freezes the fade until a start.
      write_regs(8'd1, 1'b1);
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd1, 8'h00);
      send_word(ACT_START, 8'd0, 8'h00);
      send_word(ACT_TICK, 8'd0, 8'h00);
      send_word(ACT_RD_CANVAS, 8'd2, 8'h00);
   endtask

   task automatic test_backpressure();
      stall_orders = stall_orders + 1;
      repeat (12) send_random_word();
      wait_for_results();
      repeat (8) send_random_word();
   endtask

   task automatic test_random_traffic();
      int pick;
      logic [7:0] steps;
      for (int phase = 0; phase < 4; phase++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            steps = 8'd0;
         end else if (pick < 14) begin
            steps = 8'd255;
         end else if (pick < 75) begin
            steps = 8'($urandom_range(6, 1));
         end else begin
            steps = 8'($urandom_range(40, 7));
         end
         write_regs(steps, 1'($urandom_range(1)));
         calm = (phase == 2);
         send_word(ACT_START, 8'($urandom), 8'($urandom));
         repeat (11) send_random_word();
         calm = 1'b0;
      end
   endtask

   initial begin
      for (int k = 0; k < CHANNELS; k++) begin
         canvas_mem[k] = '0;
         target_mem[k] = '0;
      end
      for (int p = 0; p < PIXELS_DEF; p++) mask_mem[p] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_store_access();
      test_load_targets();
      test_fade_extremes();
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("rgb_frame_crossfade_engine_core verification clean");
      end else begin
         $display("rgb_frame_crossfade_engine_core verification failed");
      end
      $finish;
   end

   // Result checker and receiver flow control.
   always @(posedge clock) begin
      crossfade_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation waiting");
            fault_count = fault_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %0d, got %0d", want.read_data, rsp_read_data);
               fault_count = fault_count + 1;
            end
            if (rsp_step_count !== want.step_count) begin
               $error("step_count: expected %0d, got %0d", want.step_count, rsp_step_count);
               fault_count = fault_count + 1;
            end
            if (rsp_done_res !== want.done_res) begin
               $error("done_res: expected %0d, got %0d", want.done_res, rsp_done_res);
               fault_count = fault_count + 1;
            end
         end
      end
      if (stall_orders != stall_served) begin
         stall_served = stall_orders;
         stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == HANG_LIMIT) begin
         $display("rgb_frame_crossfade_engine_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
hdl/rfce_pkg.sv
hdl/rfce_ctrl.sv
hdl/rfce_dpath.sv
hdl/rgb_frame_crossfade_engine_core.sv
hdl/rfce_checker.sv
bench/tb_top.sv
